@@ src/lse_pkg.sv @@
package lse_pkg;

    localparam int ANCHOR_COUNT = 12;
    localparam int MV_W = 16;
    localparam int PCT_W = 7;
    localparam int HALF_W = 8;
    localparam int DV_W = 8;
    localparam int SEG_W = 4;
    localparam int DIFF_W = 8;
    localparam int SLOPE_W = 5;
    localparam int PROD_W = DIFF_W + SLOPE_W;
    localparam int QUO_W = 5;

    // Curve anchors, highest voltage first
    localparam logic [MV_W-1:0] ANCHOR_MV [ANCHOR_COUNT] = '{
        16'd4200, 16'd4100, 16'd4000, 16'd3900, 16'd3800, 16'd3700,
        16'd3600, 16'd3500, 16'd3400, 16'd3300, 16'd3200, 16'd3000
    };
    localparam logic [PCT_W-1:0] ANCHOR_PCT [ANCHOR_COUNT] = '{
        7'd100, 7'd94, 7'd85, 7'd74, 7'd60, 7'd45,
        7'd28, 7'd15, 7'd8, 7'd4, 7'd2, 7'd0
    };

    // Percent gained per 100 mV in the segment whose lower anchor is entry k.
    // The bottom segment spans 200 mV for 2 percent, so it reads as 1 per 100 mV.
    localparam logic [SLOPE_W-1:0] SEG_SLOPE [ANCHOR_COUNT] = '{
        5'd0, 5'd6, 5'd9, 5'd11, 5'd14, 5'd15,
        5'd17, 5'd13, 5'd7, 5'd4, 5'd2, 5'd1
    };

    localparam int SEG_SPAN_MV = 100;
    localparam int QUO_STEPS = 17;

    // Decivolt rounding: (mv + 50) / 100 by reciprocal 5243 / 2^19
    localparam int DV_SAT = 254;
    localparam logic [MV_W-1:0] DV_SAT_MV = 16'(DV_SAT * 100 - 50);
    localparam int DV_X_W = 15;
    localparam int DV_RECIP_W = 13;
    localparam logic [DV_RECIP_W-1:0] DV_RECIP = 13'd5243;
    localparam int DV_SHIFT = 19;
    localparam int DV_PROD_W = DV_X_W + DV_RECIP_W;

    typedef struct packed {
        logic [PCT_W-1:0]  pct;
        logic [HALF_W-1:0] half;
        logic [DV_W-1:0]   dv;
    } lse_result_t;

endpackage

@@ src/lse_soc_calc.sv @@
module lse_soc_calc (
    input  logic [lse_pkg::MV_W-1:0] mv,
    output lse_pkg::lse_result_t     res
);
    import lse_pkg::*;

    logic [SEG_W-1:0]      seg;
    logic                  above;
    logic                  below;
    logic [MV_W-1:0]       diff_full;
    logic [DIFF_W-1:0]     diff;
    logic [PROD_W-1:0]     prod;
    logic [QUO_W-1:0]      quo;
    logic [PCT_W-1:0]      pct;
    logic [MV_W-1:0]       dv_x_full;
    logic [DV_PROD_W-1:0]  dv_prod;
    logic [DV_W-1:0]       dv;

    // Pick the segment: lowest-index anchor at or below the voltage
    always_comb
    begin
        seg = SEG_W'(ANCHOR_COUNT - 1);
        for (int k = ANCHOR_COUNT - 1; k >= 1; k--)
        begin
            if (mv >= ANCHOR_MV[k])
            begin
                seg = SEG_W'(k);
            end
        end
    end

    assign above = (mv >= ANCHOR_MV[0]);
    assign below = (mv <= ANCHOR_MV[ANCHOR_COUNT-1]);

    // Offset inside the segment stays under 200 mV when in range
    assign diff_full = mv - ANCHOR_MV[seg];
    assign diff = diff_full[DIFF_W-1:0];
    assign prod = PROD_W'(diff) * PROD_W'(SEG_SLOPE[seg]);

    // Truncating divide by the 100 mV span through parallel threshold compares
    always_comb
    begin
        quo = '0;
        for (int j = 1; j < QUO_STEPS; j++)
        begin
            if (prod >= PROD_W'(j * SEG_SPAN_MV))
            begin
                quo = QUO_W'(j);
            end
        end
    end

    always_comb
    begin
        if (above)
        begin
            pct = ANCHOR_PCT[0];
        end
        else if (below)
        begin
            pct = '0;
        end
        else
        begin
            pct = ANCHOR_PCT[seg] + PCT_W'(quo);
        end
    end

    // Round to decivolts; saturate before the reciprocal multiply loses accuracy
    assign dv_x_full = mv + MV_W'(SEG_SPAN_MV / 2);
    assign dv_prod = DV_PROD_W'(dv_x_full[DV_X_W-1:0]) * DV_PROD_W'(DV_RECIP);
    assign dv = (mv >= DV_SAT_MV) ? DV_W'(DV_SAT) : dv_prod[DV_SHIFT +: DV_W];

    assign res.pct = pct;
    assign res.half = {pct, 1'b0};
    assign res.dv = dv;

endmodule

@@ src/liion_soc_estimator_unit.sv @@
// An accepted input beat is held in the input register, and its result in the
// result register. Throughput: one beat per cycle while the output is not
// stalled; curve lookup, interpolation and rounding are combinational between.
// A stalled result holds while one more input beat waits in the input register.
// Reset (rst_n low, asynchronous) empties both stages; payloads are not reset.
module liion_soc_estimator_unit (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [lse_pkg::MV_W-1:0]  battery_mv,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [lse_pkg::PCT_W-1:0] charge_percent,
    output logic [lse_pkg::HALF_W-1:0] charge_half_percent,
    output logic [lse_pkg::DV_W-1:0]  voltage_decivolts
);
    import lse_pkg::*;

    logic              in_valid_reg;
    logic              in_valid_next;
    logic [MV_W-1:0]   mv_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    lse_result_t       res_reg;
    lse_result_t       calc_res;
    logic              out_free;

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = in_valid_reg && !out_free;

    lse_soc_calc u_calc (
        .mv  (mv_reg),
        .res (calc_res)
    );

    // Advance the input stage unless it holds a beat that cannot move on
    assign in_valid_next = in_stall ? in_valid_reg : in_valid;
    assign out_valid_next = out_free ? in_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture payloads
    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            mv_reg <= battery_mv;
        end
        if (out_free && in_valid_reg)
        begin
            res_reg <= calc_res;
        end
    end

    assign out_valid = out_valid_reg;
    assign charge_percent = res_reg.pct;
    assign charge_half_percent = res_reg.half;
    assign voltage_decivolts = res_reg.dv;

    // Input side stalls only when both stages are full and the output is held
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (in_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled without a blocked output");

    // A pending input beat reaches the output once the output drains
    a_forward: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_free) |=> out_valid_reg)
        else $error("input stage beat lost");

    // Result stays within its range and the half-percent tracks the percent
    a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (res_reg.pct <= PCT_W'(100)
                           && res_reg.half == {res_reg.pct, 1'b0}))
        else $error("charge result out of range");

    // Decivolts never exceed the saturation value
    a_dv_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (res_reg.dv <= DV_W'(DV_SAT)))
        else $error("decivolt result above saturation");

endmodule
